@@ design/qecp_pkg.sv @@
// ----------------------------------------------------------------------------
// qecp_pkg
// shared types and constants of the event capture parser
// ----------------------------------------------------------------------------
package qecp_pkg;

  localparam int QueueCount     = 8;
  localparam int MaxPacketBytes = 1500;
  localparam int MaxInfos       = 72;

  localparam int LvlPos  = 6;
  localparam int TsPos   = 70;
  localparam int HdrLen  = 78;
  localparam int EvtSkip = 8;

  localparam logic [31:0] TypeMask = 32'hC000_0000;
  localparam logic [31:0] QidMask  = 32'h3800_0000;
  localparam logic [31:0] LenMask  = 32'h07F8_0000;

  localparam logic [2:0]  RstMonitoredQueue = 3'd2;
  localparam logic        RstCountPackets   = 1'b0;
  localparam logic [15:0] RstPacketsPerInfo = 16'd1;
  localparam logic [6:0]  RstInfosPerUpdate = 7'd10;

  typedef enum logic [1:0] {
    REG_MONITORED_QUEUE  = 2'd0,
    REG_COUNT_PACKETS    = 2'd1,
    REG_PACKETS_PER_INFO = 2'd2,
    REG_INFOS_PER_UPDATE = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_SHORT    = 2'd1,
    ST_STALE    = 2'd2
  } pkt_status_t;

  typedef enum logic [1:0] {
    EV_STAMP  = 2'd0,
    EV_ARRIVE = 2'd1,
    EV_DEPART = 2'd2,
    EV_DROP   = 2'd3
  } ev_type_t;

  typedef struct packed {
    logic [2:0]  monitored_queue;
    logic        count_packets;
    logic [15:0] packets_per_info;
    logic [6:0]  infos_per_update;
  } cfg_t;

  typedef struct packed {
    pkt_status_t status;
    logic [31:0] arrived;
    logic [31:0] departed;
    logic [31:0] level;
  } parse_res_t;

endpackage

@@ design/qecp_cfg.sv @@
// ----------------------------------------------------------------------------
// qecp_cfg
// apb register file holding the parser configuration
// ----------------------------------------------------------------------------
module qecp_cfg
  import qecp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_o      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.monitored_queue  <= RstMonitoredQueue;
      cfg_r.count_packets    <= RstCountPackets;
      cfg_r.packets_per_info <= RstPacketsPerInfo;
      cfg_r.infos_per_update <= RstInfosPerUpdate;
    end else if (wr_en) begin
      unique case (idx)
        REG_MONITORED_QUEUE:  cfg_r.monitored_queue  <= cfg_pwdata[2:0];
        REG_COUNT_PACKETS:    cfg_r.count_packets    <= cfg_pwdata[0];
        REG_PACKETS_PER_INFO: cfg_r.packets_per_info <= cfg_pwdata[15:0];
        REG_INFOS_PER_UPDATE: cfg_r.infos_per_update <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MONITORED_QUEUE:  cfg_prdata = {29'd0, cfg_r.monitored_queue};
      REG_COUNT_PACKETS:    cfg_prdata = {31'd0, cfg_r.count_packets};
      REG_PACKETS_PER_INFO: cfg_prdata = {16'd0, cfg_r.packets_per_info};
      REG_INFOS_PER_UPDATE: cfg_prdata = {25'd0, cfg_r.infos_per_update};
      default:              cfg_prdata = 32'd0;
    endcase
  end

endmodule

@@ design/qecp_parse.sv @@
// ----------------------------------------------------------------------------
// qecp_parse
// per-byte packet parser: header level, timestamp check, event sums
// ----------------------------------------------------------------------------
module qecp_parse
  import qecp_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MaxPacketBytes
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  cfg_t       cfg_i,
  input  logic       emit_i,
  output parse_res_t res_o
);

  localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [PW-1:0] PosMax   = PW'(MAX_PACKET_BYTES);
  localparam logic [PW-1:0] PosLvl   = PW'(LvlPos);
  localparam logic [PW-1:0] PosTs    = PW'(TsPos);
  localparam logic [PW-1:0] PosStamp = PW'(HdrLen - 1);
  localparam logic [PW-1:0] PosHdr   = PW'(HdrLen);
  localparam logic [3:0]    SkipLen  = 4'(EvtSkip);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [63:0]   shift_r, shift_nxt;
  logic [3:0]    ebl_r, ebl_nxt;
  logic [31:0]   pend_r, pend_nxt;
  logic [63:0]   newest_r, newest_nxt;
  logic          acc_r, acc_nxt;
  logic [31:0]   arr_r, arr_nxt;
  logic [31:0]   dep_r, dep_nxt;
  logic [31:0]   held_r, held_nxt;

  logic [63:0]   sh_in;
  logic [31:0]   word;
  logic [31:0]   type_bits;
  logic [31:0]   qid_bits;
  logic [31:0]   len_bits;
  ev_type_t      ev_type;
  logic [2:0]    qid;
  logic [7:0]    plen;
  logic [31:0]   amount;
  logic          track;
  logic [PW-1:0] lvl_off;
  logic [3:0]    ebl_cnt;

  assign sh_in     = {shift_r[55:0], byte_i};
  assign word      = sh_in[31:0];
  assign type_bits = word & TypeMask;
  assign qid_bits  = word & QidMask;
  assign len_bits  = word & LenMask;
  assign ev_type   = ev_type_t'(type_bits[31:30]);
  assign qid       = qid_bits[29:27];
  assign plen      = len_bits[26:19];
  assign amount    = cfg_i.count_packets ? 32'd1 : ({21'd0, plen, 3'd0} - 32'd8);
  assign track     = ({1'b0, cfg_i.monitored_queue} < 4'(QueueCount));
  assign lvl_off   = pos_r - PosLvl;

  always_comb begin
    pos_nxt    = pos_r;
    shift_nxt  = shift_r;
    ebl_nxt    = ebl_r;
    pend_nxt   = pend_r;
    newest_nxt = newest_r;
    acc_nxt    = acc_r;
    arr_nxt    = arr_r;
    dep_nxt    = dep_r;
    held_nxt   = held_r;
    ebl_cnt    = 4'd0;
    res_o      = '0;
    if (fire_i) begin
      if (pos_r == '0) begin
        acc_nxt  = 1'b0;
        ebl_nxt  = 4'd0;
        pend_nxt = held_r;
      end
      if (pos_r < PosMax) begin
        shift_nxt = sh_in;
        if (pos_r >= PosLvl && pos_r < PosTs) begin
          if (lvl_off[1:0] == 2'd3 && lvl_off[5:3] == cfg_i.monitored_queue && track &&
              lvl_off[2] == cfg_i.count_packets) begin
            pend_nxt = cfg_i.count_packets ? word : {word[28:0], 3'd0};
          end
        end else if (pos_r == PosStamp) begin
          if (newest_r > sh_in) begin
            acc_nxt = 1'b0;
          end else begin
            newest_nxt = sh_in;
            acc_nxt    = 1'b1;
            held_nxt   = pend_nxt;
          end
          ebl_nxt = 4'd0;
        end else if (pos_r >= PosHdr && acc_nxt) begin
          if (ebl_nxt >= 4'd5) begin
            ebl_nxt = (ebl_nxt == 4'd5) ? 4'd0 : ebl_nxt - 4'd1;
          end else begin
            ebl_cnt = (ebl_nxt == 4'd0) ? 4'd3 : ebl_nxt - 4'd1;
            ebl_nxt = ebl_cnt;
            if (ebl_cnt == 4'd0) begin
              if (ev_type == EV_STAMP) begin
                ebl_nxt = SkipLen;
              end else if (qid == cfg_i.monitored_queue && track) begin
                case (ev_type)
                  EV_ARRIVE: arr_nxt = arr_r + amount;
                  EV_DEPART: dep_nxt = dep_r + amount;
                  default: ;
                endcase
              end
            end
          end
        end
        pos_nxt = pos_r + PW'(1);
      end
      if (pos_r < PosStamp) begin
        res_o.status = ST_SHORT;
      end else begin
        res_o.status = acc_nxt ? ST_ACCEPTED : ST_STALE;
      end
      res_o.arrived  = arr_nxt;
      res_o.departed = dep_nxt;
      res_o.level    = held_nxt;
      if (last_i) begin
        pos_nxt = '0;
        acc_nxt = 1'b0;
        ebl_nxt = 4'd0;
      end
      if (emit_i) begin
        arr_nxt  = 32'd0;
        dep_nxt  = 32'd0;
        held_nxt = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      shift_r  <= 64'd0;
      ebl_r    <= 4'd0;
      pend_r   <= 32'd0;
      newest_r <= 64'd0;
      acc_r    <= 1'b0;
      arr_r    <= 32'd0;
      dep_r    <= 32'd0;
      held_r   <= 32'd0;
    end else begin
      pos_r    <= pos_nxt;
      shift_r  <= shift_nxt;
      ebl_r    <= ebl_nxt;
      pend_r   <= pend_nxt;
      newest_r <= newest_nxt;
      acc_r    <= acc_nxt;
      arr_r    <= arr_nxt;
      dep_r    <= dep_nxt;
      held_r   <= held_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_ebl_range: assert property (@(posedge clk) disable iff (!rst_n)
    ebl_r <= SkipLen)
    else $error("event byte counter out of range");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PosMax)
    else $error("byte position past packet limit");
`endif

endmodule

@@ design/qecp_coal.sv @@
// ----------------------------------------------------------------------------
// qecp_coal
// packet and info coalescing counters with the result register
// ----------------------------------------------------------------------------
module qecp_coal
  import qecp_pkg::*;
#(
  parameter int MAX_INFOS = MaxInfos
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fire_i,
  input  logic         last_i,
  input  cfg_t         cfg_i,
  input  parse_res_t   res_i,
  output logic         emit_o,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,
  output logic [2:0]   out_tuser
);

  localparam int IW = (MAX_INFOS > 1) ? $clog2(MAX_INFOS) : 1;
  localparam logic [6:0] InfoMax = 7'(MAX_INFOS);

  logic [15:0]   pkt_cnt_r;
  logic [IW-1:0] info_cnt_r;
  logic          out_valid_r;
  pkt_status_t   status_r;
  logic          info_r;
  logic [31:0]   arr_r;
  logic [31:0]   dep_r;
  logic [31:0]   lvl_r;
  logic [6:0]    slot_r;
  logic          full_r;

  logic [16:0]   pkt_inc;
  logic [15:0]   plim;
  logic [6:0]    ilim;
  logic [7:0]    info_inc;
  logic          full;
  logic          take;

  assign take     = fire_i && last_i;
  assign pkt_inc  = {1'b0, pkt_cnt_r} + 17'd1;
  assign plim     = (cfg_i.packets_per_info == 16'd0) ? 16'd1 : cfg_i.packets_per_info;
  assign ilim     = (cfg_i.infos_per_update == 7'd0) ? 7'd1 :
                    (cfg_i.infos_per_update > InfoMax) ? InfoMax : cfg_i.infos_per_update;
  assign info_inc = 8'(info_cnt_r) + 8'd1;
  assign full     = (info_inc >= {1'b0, ilim});
  assign emit_o   = take && !(pkt_inc < {1'b0, plim});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_cnt_r   <= 16'd0;
      info_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        pkt_cnt_r   <= emit_o ? 16'd0 : pkt_inc[15:0];
        if (emit_o) begin
          info_cnt_r <= full ? '0 : info_inc[IW-1:0];
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (take) begin
      status_r <= res_i.status;
      info_r   <= emit_o;
      arr_r    <= emit_o ? res_i.arrived : 32'd0;
      dep_r    <= emit_o ? res_i.departed : 32'd0;
      lvl_r    <= emit_o ? res_i.level : 32'd0;
      slot_r   <= emit_o ? 7'(info_cnt_r) : 7'd0;
      full_r   <= emit_o && full;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {full_r, slot_r, lvl_r, dep_r, arr_r};
  assign out_tuser  = {info_r, status_r};

`ifndef NO_ASSERTIONS
  a_info_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(info_cnt_r) < MAX_INFOS)
    else $error("info counter out of range");

  a_plain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !info_r |-> arr_r == 32'd0 && dep_r == 32'd0 && lvl_r == 32'd0 &&
                              slot_r == 7'd0 && !full_r)
    else $error("info fields set on a plain packet item");

  a_full_info: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && full_r |-> info_r)
    else $error("update full without an info record");
`endif

endmodule

@@ design/queue_event_capture_parser_core.sv @@
// ----------------------------------------------------------------------------
// queue_event_capture_parser_core
// event capture packet parser with info record coalescing
// ----------------------------------------------------------------------------
// result path: a result item follows the last byte of its packet through
// the input register, then the result register
// throughput: one byte item per cycle (a last byte waits for a free output); per-byte work is one shift, one
// 64-bit timestamp compare and one 32-bit add between the two registers
// reset: synchronous active-low rst_n clears all parser state, counters and
// configuration registers to their defaults
module queue_event_capture_parser_core
  import qecp_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MaxPacketBytes,
  parameter int MAX_INFOS        = MaxInfos
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte[7:0]
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // arrived_total[31:0], departed_total[63:32], queue_level[95:64],
  // info_slot[102:96], update_full[103]
  output logic [103:0] out_tdata,
  output logic [2:0]   out_tuser,  // packet_status[1:0], info_ready[2]
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  cfg_t       cfg;
  parse_res_t res;
  logic       emit;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       out_free;
  logic       fire;

  assign out_free  = !out_tvalid || out_tready;
  assign fire      = in_valid_r && (!in_last_r || out_free);
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  qecp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  qecp_parse #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire_i (fire),
    .byte_i (in_byte_r),
    .last_i (in_last_r),
    .cfg_i  (cfg),
    .emit_i (emit),
    .res_o  (res)
  );

  qecp_coal #(
    .MAX_INFOS (MAX_INFOS)
  ) u_coal (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire_i     (fire),
    .last_i     (in_last_r),
    .cfg_i      (cfg),
    .res_i      (res),
    .emit_o     (emit),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
